/* rtl/core/spvd_pkg.sv */
// Shared types and constants for the solenoid valve pulse-and-hold driver.
// Used by spvd_step and by the top level; depends on nothing else.
package spvd_pkg;

	localparam int VALVE_COUNT = 4;
	localparam int CNT_W = 16;
	localparam int SUP_W = 8;
	localparam int WIN_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CNT_W-1:0] FORCE_TIME_RST = CNT_W'(10);
	localparam logic [SUP_W-1:0] SUPERVISE_PERIOD_RST = SUP_W'(100);
	localparam logic FAULT_ENABLE_RST = 1'b1;

	// A sense count above this marks a bad window.
	localparam logic [WIN_W-1:0] BAD_SENSE_LIMIT = WIN_W'(1);
	// More bad windows in a row than this latch the open fault.
	localparam logic [WIN_W-1:0] BAD_WINDOW_LIMIT = WIN_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORCE_TIME       = 2'd0,
		REG_SUPERVISE_PERIOD = 2'd1,
		REG_FAULT_ENABLE     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [CNT_W-1:0] force_time;
		logic [SUP_W-1:0] supervise_period;
		logic             fault_enable;
	} cfg_t;

	typedef struct packed {
		logic [VALVE_COUNT-1:0]            pins;
		logic                              phase_div;
		logic                              drive_phase;
		logic [SUP_W-1:0]                  sup_cnt;
		logic [VALVE_COUNT-1:0]            on_bits;
		logic [VALVE_COUNT-1:0]            force_bits;
		logic [VALVE_COUNT-1:0][CNT_W-1:0] pull_cnt;
		logic [WIN_W-1:0]                  sense_cnt;
		logic [WIN_W-1:0]                  bad_cnt;
		logic                              fault;
	} state_t;

	typedef struct packed {
		logic [VALVE_COUNT-1:0] drive_pins;
		logic [VALVE_COUNT-1:0] active_mask;
		logic [VALVE_COUNT-1:0] pull_in_mask;
		logic                   open_fault;
	} res_t;

	function automatic logic [WIN_W-1:0] sat_inc(input logic [WIN_W-1:0] v);
		return (v != {WIN_W{1'b1}}) ? v + WIN_W'(1) : v;
	endfunction

endpackage

/* rtl/core/spvd_step.sv */
// Next-state and result logic for one 1 ms tick of the valve driver.
// Purely combinational; uses spvd_pkg for the state, register and result types.
module spvd_step (
	input  spvd_pkg::state_t                   cur,
	input  spvd_pkg::cfg_t                     cfg,
	input  logic [spvd_pkg::VALVE_COUNT-1:0]   requested_mask,
	input  logic                               open_sense,
	input  logic                               clear_errors,
	output spvd_pkg::state_t                   nxt,
	output spvd_pkg::res_t                     res
);
	import spvd_pkg::*;

	always_comb begin
		state_t s;
		logic   sup;
		s = cur;

		if (clear_errors) begin
			s.fault = 1'b0;
			s.bad_cnt = '0;
		end

		s.sup_cnt = s.sup_cnt + SUP_W'(1);
		sup = (s.sup_cnt >= cfg.supervise_period);

		if (sup) begin
			s.sup_cnt = '0;
			s.on_bits = requested_mask;
			if (cfg.fault_enable) begin
				// Windows are only judged once every valve has left pull-in.
				if (s.force_bits == '0) begin
					if (s.sense_cnt > BAD_SENSE_LIMIT) begin
						s.bad_cnt = sat_inc(s.bad_cnt);
					end else begin
						s.bad_cnt = '0;
					end
					s.sense_cnt = '0;
					if (s.bad_cnt > BAD_WINDOW_LIMIT) begin
						s.fault = 1'b1;
					end
				end
			end else begin
				s.fault = 1'b0;
			end

			if (s.on_bits != '0) begin
				if (s.fault) begin
					s.on_bits = '0;
					s.force_bits = '0;
				end else begin
					for (int i = 0; i < VALVE_COUNT; i++) begin
						if (s.on_bits[i] && (s.pull_cnt[i] != '0)) begin
							s.pull_cnt[i] = s.pull_cnt[i] - CNT_W'(1);
							s.force_bits[i] = 1'b1;
						end else begin
							s.force_bits[i] = 1'b0;
						end
					end
				end
			end else begin
				s.force_bits = '0;
				s.bad_cnt = '0;
			end

			for (int i = 0; i < VALVE_COUNT; i++) begin
				if (!s.on_bits[i]) begin
					s.pull_cnt[i] = cfg.force_time;
				end
			end
		end

		if (s.phase_div) begin
			s.phase_div = 1'b0;
			s.drive_phase = ~s.drive_phase;
			if (s.drive_phase) begin
				if (open_sense) begin
					s.sense_cnt = sat_inc(s.sense_cnt);
				end
				s.pins = s.pins | s.on_bits;
			end else begin
				s.pins = s.force_bits;
			end
		end else begin
			s.phase_div = 1'b1;
		end

		nxt = s;
		res.drive_pins = s.pins;
		res.active_mask = s.on_bits;
		res.pull_in_mask = s.force_bits;
		res.open_fault = s.fault;
	end

endmodule

/* rtl/core/solenoid_valve_pulse_and_hold_driver.sv */
// Top level of the solenoid valve pulse-and-hold driver.
// Depends on spvd_pkg and spvd_step.
//
// Usage: every input beat is one 1 ms tick carrying the requested valve mask,
// the sampled open-circuit sense level and an error-clear flag. The block
// answers each tick with exactly one output beat: the drive pin levels, the
// valves latched on, the valves in pull-in, and the latched open fault.
// Every second tick the drive phase toggles: the on phase raises the pins of
// all active valves, the off phase drops the pins to the pull-in mask, so a
// valve sees full drive during pull-in and 50% hold drive afterwards.
//
// Timing: an accepted tick's result is registered into the output register
// or the skid entry. One tick per clock is sustained while in_stall is low;
// the whole step is a single pass through spvd_step into the state registers.
// When the receiver stalls, a result register plus one skid entry keep
// accepting; in_stall rises only when both hold undelivered results.
// The configuration port is always ready; write it only while idle.
// Reset clears all state, restores register defaults and empties the
// output stage. No clearing pass is needed.
module solenoid_valve_pulse_and_hold_driver (
	input  logic                                clk,
	input  logic                                arst_n,
	// Tick input channel.
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [spvd_pkg::VALVE_COUNT-1:0]    requested_mask,
	input  logic                                open_sense,
	input  logic                                clear_errors,
	// Result output channel.
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [spvd_pkg::VALVE_COUNT-1:0]    drive_pins,
	output logic [spvd_pkg::VALVE_COUNT-1:0]    active_mask,
	output logic [spvd_pkg::VALVE_COUNT-1:0]    pull_in_mask,
	output logic                                open_fault,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [spvd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [spvd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import spvd_pkg::*;

	cfg_t   cfg_q;
	state_t state_q;
	state_t state_nxt;
	res_t   res_nxt;
	res_t   out_q;
	res_t   skid_q;
	logic   out_valid_q;
	logic   skid_valid_q;
	logic   in_acc;
	logic   out_acc;

	assign cfg_ready = 1'b1;

	// Register writes; an index beyond the list is accepted and ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.force_time <= FORCE_TIME_RST;
			cfg_q.supervise_period <= SUPERVISE_PERIOD_RST;
			cfg_q.fault_enable <= FAULT_ENABLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FORCE_TIME:       cfg_q.force_time <= cfg_data[CNT_W-1:0];
				REG_SUPERVISE_PERIOD: cfg_q.supervise_period <= cfg_data[SUP_W-1:0];
				REG_FAULT_ENABLE:     cfg_q.fault_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	spvd_step u_step (
		.cur            (state_q),
		.cfg            (cfg_q),
		.requested_mask (requested_mask),
		.open_sense     (open_sense),
		.clear_errors   (clear_errors),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	assign in_stall = skid_valid_q;
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;

	// Driver state advances once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pins <= '0;
			state_q.phase_div <= 1'b0;
			state_q.drive_phase <= 1'b0;
			state_q.sup_cnt <= '0;
			state_q.on_bits <= '0;
			state_q.force_bits <= '0;
			state_q.pull_cnt <= {VALVE_COUNT{FORCE_TIME_RST}};
			state_q.sense_cnt <= '0;
			state_q.bad_cnt <= '0;
			state_q.fault <= 1'b0;
		end else if (in_acc) begin
			state_q <= state_nxt;
		end
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_acc) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_acc;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_acc) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_acc) begin
				out_q <= res_nxt;
			end
		end else if (in_acc) begin
			skid_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign drive_pins = out_q.drive_pins;
	assign active_mask = out_q.active_mask;
	assign pull_in_mask = out_q.pull_in_mask;
	assign open_fault = out_q.open_fault;

`ifndef NO_ASSERTIONS
	// The skid entry only fills behind a held output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid while output register empty");

	// After an accepted tick the output register always holds a valid result on the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q)
		else $error("accepted tick produced no result");

	// A latched fault keeps every valve shut.
	a_fault_shuts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.fault |-> (state_q.on_bits == '0))
		else $error("valve latched on while open fault is set");

	// Pull-in is only ever granted to valves that are on.
	a_force_subset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.force_bits & ~state_q.on_bits) == '0)
		else $error("pull-in bit set for a valve that is off");
`endif

endmodule

/* sim/spvd_tick_checker.sv */
// Checker for the solenoid valve pulse-and-hold driver: follows register writes
// and accepted tick beats, predicts each result beat and compares it on arrival.
// Depends on spvd_pkg for widths, register indexes, limits and the result type.
module spvd_tick_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [spvd_pkg::VALVE_COUNT-1:0]    requested_mask,
	input  logic                                open_sense,
	input  logic                                clear_errors,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [spvd_pkg::VALVE_COUNT-1:0]    drive_pins,
	input  logic [spvd_pkg::VALVE_COUNT-1:0]    active_mask,
	input  logic [spvd_pkg::VALVE_COUNT-1:0]    pull_in_mask,
	input  logic                                open_fault,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [spvd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [spvd_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                  mismatch_count,
	output int                                  pending_count,
	output int                                  checked_count,
	output int                                  fault_beats
);
	timeunit 1ns;
	timeprecision 1ps;

	import spvd_pkg::*;

	// Register copies.
	logic [CNT_W-1:0] force_time;
	logic [SUP_W-1:0] supervise_period;
	logic             fault_enable;

	// Driver state as the block should hold it.
	logic [VALVE_COUNT-1:0] pins;
	logic                   divider;
	logic                   drive_on;
	logic [SUP_W-1:0]       sup_count;
	logic [VALVE_COUNT-1:0] on_bits;
	logic [VALVE_COUNT-1:0] force_bits;
	logic [CNT_W-1:0]       pull_count [VALVE_COUNT];
	logic [WIN_W-1:0]       sense_count;
	logic [WIN_W-1:0]       bad_windows;
	logic                   fault;

	res_t pending_results[$];
	res_t want;
	res_t got;

	task automatic supervision_update(input logic [VALVE_COUNT-1:0] req);
		on_bits = req;
		if (fault_enable) begin
			// Windows are only judged once no valve is in pull-in.
			if (force_bits == '0) begin
				if (sense_count > BAD_SENSE_LIMIT) begin
					if (bad_windows != {WIN_W{1'b1}})
						bad_windows = bad_windows + WIN_W'(1);
				end else begin
					bad_windows = '0;
				end
				sense_count = '0;
				if (bad_windows > BAD_WINDOW_LIMIT)
					fault = 1'b1;
			end
		end else begin
			fault = 1'b0;
		end
		if (on_bits != '0) begin
			if (fault) begin
				on_bits = '0;
				force_bits = '0;
			end else begin
				for (int v = 0; v < VALVE_COUNT; v++) begin
					if (on_bits[v] && pull_count[v] != '0) begin
						pull_count[v] = pull_count[v] - CNT_W'(1);
						force_bits[v] = 1'b1;
					end else begin
						force_bits[v] = 1'b0;
					end
				end
			end
		end else begin
			force_bits = '0;
			bad_windows = '0;
		end
		for (int v = 0; v < VALVE_COUNT; v++)
			if (!on_bits[v])
				pull_count[v] = force_time;
	endtask

	task automatic advance_tick(input logic [VALVE_COUNT-1:0] req, input logic sense,
			input logic clr, output res_t result);
		if (clr) begin
			fault = 1'b0;
			bad_windows = '0;
		end
		sup_count = sup_count + SUP_W'(1);
		// A zero period behaves like one: supervision every tick.
		if (sup_count >= supervise_period) begin
			sup_count = '0;
			supervision_update(req);
		end
		if (divider) begin
			divider = 1'b0;
			drive_on = !drive_on;
			if (drive_on) begin
				if (sense && sense_count != {WIN_W{1'b1}})
					sense_count = sense_count + WIN_W'(1);
				pins = pins | on_bits;
			end else begin
				pins = force_bits;
			end
		end else begin
			divider = 1'b1;
		end
		result.drive_pins = pins;
		result.active_mask = on_bits;
		result.pull_in_mask = force_bits;
		result.open_fault = fault;
	endtask

	task automatic check_field(input string name, input logic [VALVE_COUNT-1:0] exp_v,
			input logic [VALVE_COUNT-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, actual %h", name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_time = FORCE_TIME_RST;
			supervise_period = SUPERVISE_PERIOD_RST;
			fault_enable = FAULT_ENABLE_RST;
			pins = '0;
			divider = 1'b0;
			drive_on = 1'b0;
			sup_count = '0;
			on_bits = '0;
			force_bits = '0;
			for (int v = 0; v < VALVE_COUNT; v++)
				pull_count[v] = FORCE_TIME_RST;
			sense_count = '0;
			bad_windows = '0;
			fault = 1'b0;
			pending_results.delete();
			mismatch_count = 0;
			checked_count = 0;
			fault_beats = 0;
			pending_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_FORCE_TIME: force_time = cfg_data[CNT_W-1:0];
					REG_SUPERVISE_PERIOD: supervise_period = cfg_data[SUP_W-1:0];
					REG_FAULT_ENABLE: fault_enable = cfg_data[0];
					default: ;
				endcase
			end
			// Results leave only after their tick has been registered, so compare first.
			if (out_valid && !out_stall) begin
				got.drive_pins = drive_pins;
				got.active_mask = active_mask;
				got.pull_in_mask = pull_in_mask;
				got.open_fault = open_fault;
				checked_count++;
				if (open_fault)
					fault_beats++;
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected: %p", got);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("drive_pins", want.drive_pins, got.drive_pins);
					check_field("active_mask", want.active_mask, got.active_mask);
					check_field("pull_in_mask", want.pull_in_mask, got.pull_in_mask);
					check_field("open_fault", VALVE_COUNT'(want.open_fault),
						VALVE_COUNT'(got.open_fault));
				end
			end
			if (in_valid && !in_stall) begin
				advance_tick(requested_mask, open_sense, clear_errors, want);
				pending_results.push_back(want);
			end
			pending_count <= pending_results.size();
		end
	end

endmodule

/* sim/testbench.sv */
// Top of the simulation for the solenoid valve pulse-and-hold driver: clock,
// reset, tick and register stimulus, receiver stalls and the final verdict.
// Depends on spvd_pkg, the driver RTL and spvd_tick_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import spvd_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [VALVE_COUNT-1:0] requested_mask;
	logic                   open_sense;
	logic                   clear_errors;
	logic                   out_valid;
	logic                   out_stall;
	logic [VALVE_COUNT-1:0] drive_pins;
	logic [VALVE_COUNT-1:0] active_mask;
	logic [VALVE_COUNT-1:0] pull_in_mask;
	logic                   open_fault;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int mismatch_count;
	int pending_count;
	int checked_count;
	int fault_beats;

	// Idle percentages for the two sides; the stimulus process changes them
	// between phases.
	int sender_idle_pct;
	int recv_stall_pct;
	int ticks_sent;
	int settings_applied;

	solenoid_valve_pulse_and_hold_driver dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.requested_mask(requested_mask),
		.open_sense(open_sense),
		.clear_errors(clear_errors),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive_pins(drive_pins),
		.active_mask(active_mask),
		.pull_in_mask(pull_in_mask),
		.open_fault(open_fault),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	spvd_tick_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.requested_mask(requested_mask),
		.open_sense(open_sense),
		.clear_errors(clear_errors),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive_pins(drive_pins),
		.active_mask(active_mask),
		.pull_in_mask(pull_in_mask),
		.open_fault(open_fault),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.pending_count(pending_count),
		.checked_count(checked_count),
		.fault_beats(fault_beats)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The receiver decides afresh at every edge whether to hold off the next
	// result beat, so stalls land on every phase of the drive cycle.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Hard stop. The slowest legal run is well under a tenth of this.
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Offers one tick beat and returns once it has been taken. Idle cycles
	// are inserted ahead of the beat; a stalled beat is held unchanged.
	task automatic send_tick(input logic [VALVE_COUNT-1:0] mask, input logic sense,
			input logic clr);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		requested_mask <= mask;
		open_sense <= sense;
		clear_errors <= clr;
		do
			@(posedge clk);
		while (in_stall);
		ticks_sent++;
	endtask

	// The checker publishes its backlog through a register, so the count is only
	// trusted once it is sampled at a later edge than the last beat.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_count != 0);
	endtask

	// Registers are only touched while no result is outstanding. Every tick
	// yields a result, so an empty backlog means the block is idle.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(input logic [CNT_W-1:0] ft, input logic [SUP_W-1:0] period,
			input logic enable);
		write_reg(REG_FORCE_TIME, CFG_DATA_W'(ft));
		write_reg(REG_SUPERVISE_PERIOD, CFG_DATA_W'(period));
		write_reg(REG_FAULT_ENABLE, CFG_DATA_W'(enable));
		settings_applied++;
	endtask

	// Random ticks. Most of the traffic is runs of a steady valve request with
	// a sense line that is quiet, noisy or stuck high, since a valve has to be
	// held through pull-in and several supervision windows before the open
	// fault can latch. The rest is fully random noise. Within runs, error
	// clears are rare so that faults get a chance to build up and stay latched.
	task automatic random_ticks(input int count);
		int left;
		int run_len;
		int sense_pct;
		logic [VALVE_COUNT-1:0] mask;
		left = count;
		while (left > 0) begin
			if ($urandom_range(99) < 15) begin
				send_tick(VALVE_COUNT'($urandom_range(15)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				left--;
			end else begin
				mask = VALVE_COUNT'($urandom_range(15));
				run_len = $urandom_range(1, 120);
				case ($urandom_range(2))
					0: sense_pct = 0;
					1: sense_pct = 50;
					default: sense_pct = 95;
				endcase
				while (run_len > 0 && left > 0) begin
					send_tick(mask, $urandom_range(99) < sense_pct,
						$urandom_range(59) == 0);
					run_len--;
					left--;
				end
			end
			// Now and then the sender waits for the receiver to catch up.
			if ($urandom_range(199) == 0)
				wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		requested_mask = '0;
		open_sense = 1'b0;
		clear_errors = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FORCE_TIME;
		cfg_data = '0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		ticks_sent = 0;
		settings_applied = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the shortest nonzero pull-in and supervision every tick.
		// All valves together, nothing requested, each valve alone, and error
		// clears with the sense line high.
		apply_settings(CNT_W'(1), SUP_W'(1), 1'b1);
		repeat (4) send_tick(4'hF, 1'b1, 1'b0);
		repeat (2) send_tick(4'h0, 1'b0, 1'b0);
		send_tick(4'h1, 1'b0, 1'b0);
		send_tick(4'h2, 1'b1, 1'b0);
		send_tick(4'h4, 1'b0, 1'b0);
		send_tick(4'h8, 1'b1, 1'b0);
		repeat (2) send_tick(4'hF, 1'b1, 1'b1);

		// A zero supervision period behaves as one, and no pull-in at all.
		apply_settings(CNT_W'(0), SUP_W'(0), 1'b1);
		send_tick(4'h5, 1'b0, 1'b0);
		send_tick(4'hA, 1'b1, 1'b0);
		send_tick(4'hF, 1'b0, 1'b0);
		send_tick(4'hF, 1'b1, 1'b0);

		// Fault detection off with the longest pull-in.
		apply_settings(CNT_W'(16'hFFFF), SUP_W'(1), 1'b0);
		repeat (4) send_tick(4'hF, 1'b1, 1'b0);
		send_tick(4'hF, 1'b1, 1'b1);

		// Random part. First the receiver mostly stalls while the sender is
		// nearly always ready; windows of nine ticks let the fault latch.
		sender_idle_pct = 11;
		recv_stall_pct = 83;
		apply_settings(CNT_W'(2), SUP_W'(9), 1'b1);
		random_ticks(210);
		apply_settings(CNT_W'(0), SUP_W'(0), 1'b1);
		random_ticks(210);

		// Then the sender mostly idles and the receiver rarely stalls.
		sender_idle_pct = 83;
		recv_stall_pct = 11;
		apply_settings(CNT_W'(16'hFFFF), SUP_W'(1), 1'b0);
		random_ticks(210);
		apply_settings(CNT_W'(0), SUP_W'(8'hFF), 1'b1);
		random_ticks(300);

		// Finally full rate on both sides.
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		apply_settings(CNT_W'(1), SUP_W'(8), 1'b1);
		random_ticks(210);
		apply_settings(CNT_W'($urandom_range(6)), SUP_W'($urandom_range(2, 16)),
			1'($urandom_range(1)));
		random_ticks(210);

		// Drain, then keep clocking so that the output stage can show any stray
		// beat before the verdict.
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Run covered %0d ticks over %0d register settings, including full stall",
			ticks_sent, settings_applied);
		$display("pressure on each side; %0d results checked, %0d with the open fault set.",
			checked_count, fault_beats);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
